FILE: rtl/longest_ones_window_k_gaps_top_macros.svh
// Assertion macros for the longest ones window block.
// Each use expands to one concurrent assertion clocked on clk_i, reset by rst_ni.
`ifndef LONGEST_ONES_WINDOW_K_GAPS_TOP_MACROS_SVH
`define LONGEST_ONES_WINDOW_K_GAPS_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define LOWKG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define LOWKG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lowkg_pkg.sv
// Shared constants and types for the longest ones window block.
// No dependencies.
package lowkg_pkg;

  localparam int unsigned LOWKG_MAX_GAPS = 16;
  localparam int unsigned LOWKG_LEN_BITS = 20;

  localparam int unsigned GAP_W      = 5;
  localparam int unsigned OUT_W      = 20;
  localparam int unsigned APB_DW     = 32;
  localparam int unsigned CFG_ADDR_W = 2;

  localparam int unsigned REG_GAP_LIMIT = 0;

  localparam logic [GAP_W-1:0] GAP_LIMIT_RESET = GAP_W'(1);

  typedef struct packed {
    logic bit_value;
    logic is_final;
  } lowkg_beat_t;

endpackage

FILE: rtl/longest_ones_window_k_gaps_top.sv
// Longest ones window, at most gap_limit zero runs (0 as 1, max MAX_GAPS), one bit per beat.
// Throughput: one input beat per cycle unless a final beat waits on a stalled result output;
// one result on each final bit, via the input register and then the result register.
// Reset: rst_ni async active low; clears stream state and sets gap_limit to 1.
// Depends on lowkg_pkg, lowkg_tracker and longest_ones_window_k_gaps_top_macros.svh.
`include "longest_ones_window_k_gaps_top_macros.svh"

module longest_ones_window_k_gaps_top import lowkg_pkg::*; #(
  parameter int unsigned MAX_GAPS = LOWKG_MAX_GAPS,
  parameter int unsigned LEN_BITS = LOWKG_LEN_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready,
  input  logic                  bit_value_i,
  input  logic                  is_final_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic [OUT_W-1:0]      best_length_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i
);

  logic [GAP_W-1:0]    gap_q;
  logic                reg_hit;
  logic                s1_valid_q, s1_valid_d;
  lowkg_beat_t         s1_q;
  logic                in_fire;
  logic                out_free;
  logic                step;
  logic                out_valid_q, out_valid_d;
  logic [OUT_W-1:0]    best_length_q;
  logic [LEN_BITS-1:0] best_next;
  logic [LEN_BITS+OUT_W-1:0] best_ext;

  assign pready  = 1'b1;
  assign reg_hit = (paddr >> 2) == CFG_ADDR_W'(REG_GAP_LIMIT);
  assign prdata  = reg_hit ? APB_DW'(gap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= GAP_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      gap_q <= pwdata[GAP_W-1:0];
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && (!s1_q.is_final || out_free);
  assign in_ready_o = !s1_valid_q || step;
  assign in_fire    = in_valid_i && in_ready_o;
  assign s1_valid_d = in_fire || (s1_valid_q && !step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.bit_value <= bit_value_i;
      s1_q.is_final  <= is_final_i;
    end
  end

  lowkg_tracker #(
    .MAX_GAPS (MAX_GAPS),
    .LEN_BITS (LEN_BITS)
  ) u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .beat_i      (s1_q),
    .gap_limit_i (gap_q),
    .best_o      (best_next)
  );

  assign best_ext    = (LEN_BITS + OUT_W)'(best_next);
  assign out_valid_d = (step && s1_q.is_final) || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && s1_q.is_final) begin
      best_length_q <= best_ext[OUT_W-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign best_length_o = best_length_q;

  `LOWKG_ASSERT_NEXT(a_final_gives_result, step && s1_q.is_final, out_valid_q, "final beat lost")
  `LOWKG_ASSERT_SAME(a_stall_needs_beat, !in_ready_o, s1_valid_q, "stall without held beat")
  `LOWKG_ASSERT_NEXT(a_final_held, s1_valid_q && s1_q.is_final && out_valid_q && !out_ready_i, s1_valid_q, "blocked final beat dropped")

endmodule

FILE: rtl/lowkg_tracker.sv
// Stream state of the longest ones window block: position, zero run end line, best score.
// Depends on lowkg_pkg.
module lowkg_tracker import lowkg_pkg::*; #(
  parameter int unsigned MAX_GAPS = LOWKG_MAX_GAPS,
  parameter int unsigned LEN_BITS = LOWKG_LEN_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  lowkg_beat_t         beat_i,
  input  logic [GAP_W-1:0]    gap_limit_i,
  output logic [LEN_BITS-1:0] best_o
);

  localparam int unsigned JW = $clog2(MAX_GAPS + 2);
  localparam int unsigned IW = $clog2(MAX_GAPS + 1);
  localparam int unsigned CW = JW + GAP_W;

  logic [LEN_BITS-1:0] pos_q, pos_d;
  logic                prev_q;
  logic [JW-1:0]       seen_q, seen_d;
  logic [LEN_BITS-1:0] best_q, best_d;
  logic [LEN_BITS-1:0] ends_q [MAX_GAPS+1];
  logic [LEN_BITS-1:0] ends_v [MAX_GAPS+1];

  logic                push;
  logic [CW-1:0]       gap_ext;
  logic [JW-1:0]       k;
  logic [JW-1:0]       j;
  logic [JW-1:0]       idx;
  logic [LEN_BITS-1:0] run_end;
  logic [LEN_BITS-1:0] score;

  assign push  = beat_i.bit_value && !prev_q;
  assign pos_d = (&pos_q) ? pos_q : pos_q + LEN_BITS'(1);

  always_comb begin
    seen_d = seen_q;
    if (push && (seen_q < JW'(MAX_GAPS + 1))) begin
      seen_d = seen_q + JW'(1);
    end
  end

  always_comb begin
    ends_v[0] = push ? pos_q : ends_q[0];
    for (int unsigned i = 1; i <= MAX_GAPS; i++) begin
      ends_v[i] = push ? ends_q[i-1] : ends_q[i];
    end
  end

  always_comb begin
    gap_ext = CW'(gap_limit_i);
    if (gap_ext == CW'(0)) begin
      k = JW'(1);
    end else if (gap_ext > CW'(MAX_GAPS)) begin
      k = JW'(MAX_GAPS);
    end else begin
      k = gap_ext[JW-1:0];
    end
    j   = beat_i.bit_value ? k + JW'(1) : k;
    idx = j - JW'(1);
    run_end = (j <= seen_d) ? ends_v[idx[IW-1:0]] : '0;
    score   = (run_end < pos_d) ? pos_d - run_end : '0;
    best_d  = (score > best_q) ? score : best_q;
  end

  assign best_o = best_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      prev_q <= 1'b1;
      seen_q <= '0;
      best_q <= '0;
    end else if (step_i) begin
      if (beat_i.is_final) begin
        pos_q  <= '0;
        prev_q <= 1'b1;
        seen_q <= '0;
        best_q <= '0;
      end else begin
        pos_q  <= pos_d;
        prev_q <= beat_i.bit_value;
        seen_q <= seen_d;
        best_q <= best_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && push) begin
      for (int unsigned i = 0; i <= MAX_GAPS; i++) begin
        ends_q[i] <= ends_v[i];
      end
    end
  end

endmodule

FILE: verif/longest_ones_window_k_gaps_top_test.sv
// Self-checking bench for longest_ones_window_k_gaps_top: random and fixed strings, APB limit writes, reads.
// A predictor class tracks the zero-run window per beat and scores each final-bit result.
// Depends on lowkg_pkg and the RTL top only.
module longest_ones_window_k_gaps_top_test;
  import lowkg_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned DRAIN_CYCLES   = 6;
  localparam int unsigned PHASE_BEATS    = 170;
  localparam int unsigned NUM_PHASES     = 8;
  localparam longint      POS_MAX        = (64'd1 << LOWKG_LEN_BITS) - 1;
  localparam logic [CFG_ADDR_W-1:0] GAP_LIMIT_ADDR = CFG_ADDR_W'(4 * REG_GAP_LIMIT);

  class gap_window_predictor;
    bit [GAP_W-1:0]   gap_limit;
    longint           position;
    longint           best_score;
    bit               prev_bit;
    longint           run_ends[LOWKG_MAX_GAPS + 1];
    int               runs_held;
    logic [OUT_W-1:0] expected_best[$];
    int               mismatches;

    function new();
      gap_limit  = GAP_LIMIT_RESET;
      mismatches = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      position   = 0;
      prev_bit   = 1'b1;
      runs_held  = 0;
      best_score = 0;
      foreach (run_ends[i]) run_ends[i] = 0;
    endfunction

    function void set_limit(bit [GAP_W-1:0] value);
      gap_limit = value;
    endfunction

    function longint end_back(int j);
      if (j == 0 || j > runs_held) return 0;
      return run_ends[j - 1];
    endfunction

    function void close_zero_run(longint stop);
      for (int i = LOWKG_MAX_GAPS; i > 0; i--) run_ends[i] = run_ends[i - 1];
      run_ends[0] = stop;
      if (runs_held < LOWKG_MAX_GAPS + 1) runs_held++;
    endfunction

    function void note_bit(bit b, bit fin);
      int     k;
      longint p;
      longint e;
      longint score;
      k = gap_limit;
      if (k < 1) k = 1;
      if (k > LOWKG_MAX_GAPS) k = LOWKG_MAX_GAPS;
      p = (position < POS_MAX) ? position + 1 : POS_MAX;
      if (b && !prev_bit) close_zero_run(position);
      e = b ? end_back(k + 1) : end_back(k);
      score = (e < p) ? p - e : 0;
      if (score > best_score) best_score = score;
      prev_bit = b;
      position = p;
      if (fin) begin
        expected_best = {expected_best, best_score[OUT_W-1:0]};
        clear_stream();
      end
    endfunction

    function void report(string what, longint want, logic [APB_DW-1:0] got);
      mismatches++;
      if (mismatches <= 10) $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endfunction

    function void check_best(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      if (expected_best.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected best_length beat: %0d", got);
        return;
      end
      want = expected_best.pop_front();
      if (got !== want) report("best_length", want, got);
    endfunction

    function void check_limit_read(logic [GAP_W-1:0] got);
      if (got !== gap_limit) report("gap_limit read", gap_limit, got);
    endfunction

    function int pending();
      return expected_best.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [APB_DW-1:0]     pwdata;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;
  logic                  bit_value_i;
  logic                  is_final_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [OUT_W-1:0]      best_length_o;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;

  gap_window_predictor pred = new();

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_left    = 0;
  int unsigned hold_reqs    = 0;
  int unsigned hold_done    = 0;
  int unsigned quiet_cycles = 0;

  longest_ones_window_k_gaps_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .bit_value_i   (bit_value_i),
    .is_final_i    (is_final_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .best_length_o (best_length_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) pred.note_bit(bit_value_i, is_final_i);
    if (rst_ni && out_valid_o && out_ready_i) pred.check_best(best_length_o);
  end

  // Hold off the result side for a long stretch on request, else stall at random.
  always @(posedge clk_i) begin
    if (hold_done != hold_reqs) begin
      hold_left = HOLD_CYCLES;
      hold_done = hold_reqs;
    end
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[longest_ones_window_k_gaps_top] ERROR");
      $finish;
    end
  end

  task automatic send_beat(input bit b, input bit fin);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    bit_value_i <= b;
    is_final_i  <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_string(input int unsigned len, input int unsigned zero_pct);
    for (int unsigned i = 0; i < len; i++) begin
      send_beat($urandom_range(0, 99) >= zero_pct, i == len - 1);
    end
  endtask

  task automatic send_pattern(input string bits);
    for (int i = 0; i < bits.len(); i++) send_beat(bits[i] == "1", i == bits.len() - 1);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pred.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input bit [GAP_W-1:0] value);
    logic [APB_DW-1:0] word;
    word = $urandom();
    word[GAP_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= GAP_LIMIT_ADDR;
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    pred.set_limit(value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= GAP_LIMIT_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    pred.check_limit_read(prdata[GAP_W-1:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(input bit do_hold, input bit do_pause);
    int unsigned sent;
    int unsigned len;
    bit          mid_done;
    sent     = 0;
    mid_done = 1'b0;
    while (sent < PHASE_BEATS) begin
      len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 24) : $urandom_range(25, 120);
      send_string(len, $urandom_range(0, 100));
      sent += len;
      if (!mid_done && sent >= PHASE_BEATS / 2) begin
        mid_done = 1'b1;
        if (do_hold) begin
          hold_reqs++;
          repeat (60) send_string($urandom_range(1, 3), $urandom_range(0, 100));
          sent += 120;
        end
        if (do_pause) wait_idle();
      end
    end
  endtask

  initial begin
    int unsigned idle_of[4];
    int unsigned stall_of[4];
    bit [GAP_W-1:0] limit_of[NUM_PHASES];
    idle_of  = '{0, 76, 0, 36};
    stall_of = '{0, 0, 76, 36};
    limit_of = '{5'd0, 5'd16, 5'd31, 5'd1, 5'd17, GAP_W'($urandom_range(2, 15)),
                 GAP_W'($urandom_range(0, 31)), 5'd16};
    idle_pct     = 0;
    stall_pct    = 0;
    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    bit_value_i <= 1'b0;
    is_final_i  <= 1'b0;
    in_valid_i  <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_read();
    send_pattern("1");
    send_pattern("0");
    send_pattern("0100110");
    send_pattern("1011101");
    send_pattern("00000");
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      apb_write(limit_of[p]);
      apb_read();
      idle_pct  = idle_of[p % 4];
      stall_pct = stall_of[p % 4];
      run_phase(p == 0, p == 1);
      wait_idle();
    end

    if (pred.mismatches == 0 && pred.pending() == 0) begin
      $display("[longest_ones_window_k_gaps_top] OK");
    end else begin
      $display("[longest_ones_window_k_gaps_top] ERROR");
    end
    $finish;
  end

endmodule
